// ===== sv/isst_pkg.sv =====
// isst_pkg: shared constants, codes and the command struct of the indexed sequence store
// depends on nothing; used by isst_ctrl, isst_cell and indexed_sequence_store_top

package isst_pkg;

    // default depth of the list
    localparam int CAPACITY_DEF = 16;

    // width of one stored word
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // value returned when no read takes place
    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    // decision for one word, handed from the controller to the cell row
    typedef struct packed {
        logic       ins;
        logic       del;
        logic       rd;
        logic [1:0] status;
    } t_cmd;

endpackage

// ===== sv/isst_ctrl.sv =====
// isst_ctrl: checks one operation against the entry count and decides what the cells do
// depends on isst_pkg

module isst_ctrl #(
    parameter int CAPACITY = isst_pkg::CAPACITY_DEF,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic [1:0]    i_operation,
    input  logic          i_at_end,
    input  logic [CW-1:0] i_position,
    input  logic [CW-1:0] i_count,
    output isst_pkg::t_cmd o_cmd,
    output logic [CW-1:0] o_pos
);

    logic w_full;
    logic w_empty;

    assign w_full  = (i_count == CW'(CAPACITY));
    assign w_empty = (i_count == '0);

    // decode and range checks
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = isst_pkg::ST_OK;
        o_pos        = i_position;
        unique case (i_operation)
            isst_pkg::OP_INSERT: begin
                // a full list is refused before the position is looked at
                if (w_full) begin
                    o_cmd.status = isst_pkg::ST_FULL;
                end else begin
                    if (i_at_end) begin
                        o_pos = i_count;
                    end
                    if (o_pos > i_count) begin
                        o_cmd.status = isst_pkg::ST_BADPOS;
                    end else begin
                        o_cmd.ins = 1'b1;
                    end
                end
            end
            isst_pkg::OP_DELETE: begin
                if (w_empty) begin
                    o_cmd.status = isst_pkg::ST_EMPTY;
                end else begin
                    if (i_at_end) begin
                        o_pos = i_count - CW'(1);
                    end
                    if (o_pos >= i_count) begin
                        o_cmd.status = isst_pkg::ST_BADPOS;
                    end else begin
                        o_cmd.del = 1'b1;
                    end
                end
            end
            isst_pkg::OP_READ: begin
                if (w_empty) begin
                    o_cmd.status = isst_pkg::ST_EMPTY;
                end else if (i_position >= i_count) begin
                    o_cmd.status = isst_pkg::ST_BADPOS;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            default: begin
                // unused operation code
                o_cmd.status = isst_pkg::ST_BADPOS;
            end
        endcase
    end

endmodule

// ===== sv/isst_cell.sv =====
// isst_cell: one list position; takes its left or right neighbour's word on a shift
// depends on isst_pkg

module isst_cell #(
    parameter int CAPACITY = isst_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  isst_pkg::t_cmd              i_cmd,
    input  logic [CW-1:0]               i_pos,
    input  logic [isst_pkg::DATA_W-1:0] i_new,
    input  logic [isst_pkg::DATA_W-1:0] i_left,
    input  logic [isst_pkg::DATA_W-1:0] i_right,
    output logic [isst_pkg::DATA_W-1:0] o_data
);

    logic [isst_pkg::DATA_W-1:0] r_data;
    logic [isst_pkg::DATA_W-1:0] n_data;
    logic                        w_above;
    logic                        w_here;

    assign w_above = (CW'(INDEX) > i_pos);
    assign w_here  = (CW'(INDEX) == i_pos);

    // insert shifts up from the left, delete shifts down from the right
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (w_above) begin
                n_data = i_left;
            end else if (w_here) begin
                n_data = i_new;
            end
        end else if (i_cmd.del) begin
            if (w_above || w_here) begin
                n_data = i_right;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/indexed_sequence_store_top.sv =====
// indexed_sequence_store_top: bounded ordered list of signed words held in a row of cells
// depends on isst_pkg, isst_ctrl and isst_cell
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+--------------------------------------------
//  in       | i_valid | o_stall | i_operation, i_at_end, i_position, i_value
//  out      | o_valid | i_stall | o_read_value, o_status, o_entry_count
//
// one word per cycle unless the output stalls: every cell shifts in the
// same cycle, so an insert or delete anywhere in the list is one shift;
// the result is registered and appears the cycle after acceptance.
// the output register holds the result while i_stall is high; a new word is
// taken when the output is empty or being taken in the same cycle.
// synchronous active-low reset clears the count and the output valid; the
// stored words are left as they are and never read before written.

module indexed_sequence_store_top #(
    parameter int CAPACITY = isst_pkg::CAPACITY_DEF,
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int IW      = $clog2(CAPACITY)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_operation,
    input  logic                               i_at_end,
    input  logic [CW-1:0]                      i_position,
    input  logic signed [isst_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [isst_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                         o_status,
    output logic [CW-1:0]                      o_entry_count
);

    logic                        w_accept;
    isst_pkg::t_cmd              w_cmd;
    logic [CW-1:0]               w_pos;
    logic [isst_pkg::DATA_W-1:0] w_data [CAPACITY];

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_valid;
    logic [isst_pkg::DATA_W-1:0] r_read_value;
    logic [1:0]                  r_status;

    // handshake
    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // decision for this word
    isst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_operation (i_operation),
        .i_at_end    (i_at_end),
        .i_position  (i_position),
        .i_count     (r_count),
        .o_cmd       (w_cmd),
        .o_pos       (w_pos)
    );

    // row of cells, each wired to its neighbours
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [isst_pkg::DATA_W-1:0] w_left;
        logic [isst_pkg::DATA_W-1:0] w_right;

        if (k == 0) begin : g_head
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_tail
            assign w_right = w_data[k];
        end else begin : g_body
            assign w_right = w_data[k+1];
        end

        isst_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_accept),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_new   (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k])
        );
    end

    // next count
    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_cmd.status;
            r_read_value <= w_cmd.rd ? w_data[i_position[IW-1:0]] : isst_pkg::NO_VALUE;
        end
    end

    assign o_valid       = r_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_count;

    // count stays within the list depth
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a full status is only reported when the list is full
    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == isst_pkg::ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

    // a successful insert grows the list by one
    a_insert_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // only a good read carries a value other than all ones
    a_fail_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != isst_pkg::ST_OK) |-> (o_read_value == isst_pkg::NO_VALUE))
        else $error("failed operation carries a value");

endmodule
